### rtl/hf1d_pkg.sv
// Package for the 1-D histogram filter: default sizes, register indexes,
// register reset values, operation codes and the sequencer state type.
// Used by the top level; depends on nothing.
package hf1d_pkg;

  localparam int CELLS_DEF     = 16;
  localparam int PROB_BITS_DEF = 16;

  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORLD_MAP = 3'd0,
    CFG_HIT       = 3'd1,
    CFG_MISS      = 3'd2,
    CFG_EXACT     = 3'd3,
    CFG_OVER      = 3'd4,
    CFG_UNDER     = 3'd5
  } cfg_idx_t;

  localparam logic [REG_W-1:0] WORLD_MAP_RST = 16'd6;
  localparam logic [REG_W-1:0] HIT_RST       = 16'd39322;
  localparam logic [REG_W-1:0] MISS_RST      = 16'd13107;
  localparam logic [REG_W-1:0] EXACT_RST     = 16'd52429;
  localparam logic [REG_W-1:0] OVER_RST      = 16'd6554;
  localparam logic [REG_W-1:0] UNDER_RST     = 16'd6554;

  typedef enum logic {
    OP_SENSE = 1'b0,
    OP_MOVE  = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_S_RD,
    ST_S_MUL,
    ST_S_ACC,
    ST_S_CHK,
    ST_Z_RD,
    ST_Z_GET,
    ST_D_RD,
    ST_D_LOAD,
    ST_D_ITER,
    ST_D_FIN,
    ST_M_MOD,
    ST_M_RD,
    ST_M_MUL,
    ST_M_ACC,
    ST_M_FIN,
    ST_EMIT
  } state_t;

endpackage

### rtl/hf1d_in_if.sv
// Input channel of the histogram filter: valid/ready and the item fields.
// Depends on nothing.
interface hf1d_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic              measurement;
  logic signed [4:0] motion;

  modport source (output valid, operation, measurement, motion, input ready);
  modport sink   (input valid, operation, measurement, motion, output ready);
endinterface

### rtl/hf1d_out_if.sv
// Result channel of the histogram filter: valid/ready and one belief cell.
// Depends on nothing.
interface hf1d_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cell_index;
  logic [15:0] probability;
  logic        last;
  logic        zero_sum;

  modport source (output valid, cell_index, probability, last, zero_sum, input ready);
  modport sink   (input valid, cell_index, probability, last, zero_sum, output ready);
endinterface

### rtl/histogram_filter_1d_unit.sv
// Top level of the 1-D histogram filter (Markov localization) block; uses hf1d_pkg and both interfaces.
// Sense: weighting of each cell, then each cell is normalized on the restoring divider;
// a zero sum passes the belief through unchanged, flagged as zero_sum.
// Move: reduction of the shift, then each cell is computed on the
// shared multiplier. One item at a time; result stalls hold either operation.
// Reset is synchronous; afterwards a pass over all cells loads the uniform belief.
module histogram_filter_1d_unit
  import hf1d_pkg::*;
#(
  parameter int CELLS     = CELLS_DEF,
  parameter int PROB_BITS = PROB_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hf1d_in_if.sink              in_ch,
  hf1d_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int IW  = $clog2(CELLS);
  localparam int WW  = PROB_BITS + REG_W;
  localparam int SW  = WW + IW;
  localparam int AW  = PROB_BITS + REG_W + 2;
  localparam int DCW = $clog2(PROB_BITS + 1);
  localparam int BD  = 2 * (2 ** IW);

  localparam logic [PROB_BITS-1:0] PMAX = {PROB_BITS{1'b1}};
  localparam longint unsigned UNI_L = (64'd1 << PROB_BITS) / CELLS;
  localparam logic [PROB_BITS-1:0] UNIFORM = PROB_BITS'(UNI_L);
  localparam logic [AW-1:0] ROUND = AW'(64'd1 << (REG_W - 1));
  localparam logic [IW-1:0] LAST_IDX = IW'(CELLS - 1);
  localparam logic [IW:0] CELLS_W = (IW + 1)'(CELLS);
  localparam logic signed [7:0] CELLS_S = 8'(CELLS);

  state_t state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic bank_r, bank_nxt;
  op_t op_r, op_nxt;
  logic meas_r, meas_nxt;
  logic zflag_r, zflag_nxt;
  logic signed [7:0] moff_r, moff_nxt;
  logic [1:0] term_r, term_nxt;
  logic [WW-1:0] prod_r, prod_nxt;
  logic [SW-1:0] sum_r, sum_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [SW:0] rem_r, rem_nxt;
  logic [PROB_BITS:0] quo_r, quo_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic sat_r, sat_nxt;
  logic [PROB_BITS-1:0] res_r, res_nxt;

  logic [REG_W-1:0] wmap_r, hit_r, miss_r, exact_r, over_r, under_r;

  logic out_valid_r, out_valid_nxt;
  logic [3:0] out_idx_r, out_idx_nxt;
  logic [15:0] out_prob_r, out_prob_nxt;
  logic out_last_r, out_last_nxt;
  logic out_zero_r, out_zero_nxt;

  logic [PROB_BITS-1:0] bmem [BD];
  logic [WW-1:0] wmem [CELLS];
  logic [PROB_BITS-1:0] brdata_r;
  logic [WW-1:0] wrdata_r;
  logic [IW:0] braddr, bwaddr;
  logic [PROB_BITS-1:0] bwdata;
  logic bwe, wwe;

  logic [IW:0] src_sum;
  logic [IW-1:0] src_idx, dec_idx, inc_idx, term_idx;
  logic [REG_W-1:0] mul_b;
  logic sense_wt_sel;
  logic [SW:0] r2;
  logic r2_ge;
  logic [PROB_BITS+1:0] q_inc;
  logic [PROB_BITS:0] q_half;
  logic [AW-1:0] acc_rnd;
  logic [PROB_BITS+1:0] mv_res;
  logic signed [7:0] mot_ext;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cell_index  = out_idx_r;
  assign out_ch.probability = out_prob_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.zero_sum    = out_zero_r;

  // Source cells for a move: exact, one short of it and one past it.
  assign src_sum = {1'b0, i_r} + {1'b0, moff_r[IW-1:0]};
  assign src_idx = (src_sum >= CELLS_W) ? IW'(src_sum - CELLS_W) : src_sum[IW-1:0];
  assign dec_idx = (src_idx == '0) ? LAST_IDX : src_idx - 1'b1;
  assign inc_idx = (src_idx == LAST_IDX) ? '0 : src_idx + 1'b1;

  assign sense_wt_sel = (wmap_r[4'(i_r)] == meas_r);
  assign mot_ext      = 8'(in_ch.motion);

  assign r2     = {rem_r[SW-1:0], 1'b0};
  assign r2_ge  = (r2 >= {1'b0, sum_r});
  assign q_inc  = (PROB_BITS + 2)'(quo_r) + 1'b1;
  assign q_half = q_inc[PROB_BITS+1:1];
  assign acc_rnd = acc_r + ROUND;
  assign mv_res  = acc_rnd[AW-1:REG_W];

  always_comb begin
    case (term_r)
      2'd0:    term_idx = src_idx;
      2'd1:    term_idx = dec_idx;
      default: term_idx = inc_idx;
    endcase
    if (state_r == ST_M_MUL) begin
      case (term_r)
        2'd0:    mul_b = exact_r;
        2'd1:    mul_b = over_r;
        default: mul_b = under_r;
      endcase
    end else begin
      mul_b = sense_wt_sel ? hit_r : miss_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    bank_nxt      = bank_r;
    op_nxt        = op_r;
    meas_nxt      = meas_r;
    zflag_nxt     = zflag_r;
    moff_nxt      = moff_r;
    term_nxt      = term_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dcnt_nxt      = dcnt_r;
    sat_nxt       = sat_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_idx_nxt   = out_idx_r;
    out_prob_nxt  = out_prob_r;
    out_last_nxt  = out_last_r;
    out_zero_nxt  = out_zero_r;
    braddr        = {bank_r, i_r};
    bwe           = 1'b0;
    bwaddr        = {~bank_r, i_r};
    bwdata        = res_r;
    wwe           = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        bwe    = 1'b1;
        bwaddr = {1'b0, i_r};
        bwdata = UNIFORM;
        if (i_r == LAST_IDX) begin
          i_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = op_t'(in_ch.operation);
          meas_nxt  = in_ch.measurement;
          moff_nxt  = -mot_ext;
          i_nxt     = '0;
          sum_nxt   = '0;
          zflag_nxt = 1'b0;
          term_nxt  = '0;
          state_nxt = (op_t'(in_ch.operation) == OP_MOVE) ? ST_M_MOD : ST_S_RD;
        end
      end
      ST_S_RD: begin
        state_nxt = ST_S_MUL;
      end
      ST_S_MUL: begin
        prod_nxt  = WW'(brdata_r) * WW'(mul_b);
        state_nxt = ST_S_ACC;
      end
      ST_S_ACC: begin
        wwe     = 1'b1;
        sum_nxt = sum_r + SW'(prod_r);
        if (i_r == LAST_IDX) begin
          state_nxt = ST_S_CHK;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_S_RD;
        end
      end
      ST_S_CHK: begin
        i_nxt = '0;
        if (sum_r == '0) begin
          zflag_nxt = 1'b1;
          state_nxt = ST_Z_RD;
        end else begin
          state_nxt = ST_D_RD;
        end
      end
      ST_Z_RD: begin
        state_nxt = ST_Z_GET;
      end
      ST_Z_GET: begin
        res_nxt   = brdata_r;
        state_nxt = ST_EMIT;
      end
      ST_D_RD: begin
        state_nxt = ST_D_LOAD;
      end
      ST_D_LOAD: begin
        rem_nxt   = (SW + 1)'(wrdata_r);
        sat_nxt   = (SW'(wrdata_r) >= sum_r);
        quo_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = ST_D_ITER;
      end
      ST_D_ITER: begin
        rem_nxt  = r2_ge ? (r2 - {1'b0, sum_r}) : r2;
        quo_nxt  = {quo_r[PROB_BITS-1:0], r2_ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(PROB_BITS)) begin
          state_nxt = ST_D_FIN;
        end
      end
      ST_D_FIN: begin
        if (sat_r || (q_half > {1'b0, PMAX})) begin
          res_nxt = PMAX;
        end else begin
          res_nxt = q_half[PROB_BITS-1:0];
        end
        state_nxt = ST_EMIT;
      end
      ST_M_MOD: begin
        if (moff_r < 0) begin
          moff_nxt = moff_r + CELLS_S;
        end else if (moff_r >= CELLS_S) begin
          moff_nxt = moff_r - CELLS_S;
        end else begin
          state_nxt = ST_M_RD;
        end
      end
      ST_M_RD: begin
        braddr    = {bank_r, term_idx};
        state_nxt = ST_M_MUL;
      end
      ST_M_MUL: begin
        prod_nxt  = WW'(brdata_r) * WW'(mul_b);
        state_nxt = ST_M_ACC;
      end
      ST_M_ACC: begin
        acc_nxt = ((term_r == 2'd0) ? '0 : acc_r) + AW'(prod_r);
        if (term_r == 2'd2) begin
          state_nxt = ST_M_FIN;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = ST_M_RD;
        end
      end
      ST_M_FIN: begin
        if (mv_res > (PROB_BITS + 2)'(PMAX)) begin
          res_nxt = PMAX;
        end else begin
          res_nxt = mv_res[PROB_BITS-1:0];
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 4'(i_r);
          out_prob_nxt  = 16'(res_r);
          out_last_nxt  = (i_r == LAST_IDX);
          out_zero_nxt  = zflag_r;
          bwe           = !zflag_r;
          term_nxt      = '0;
          if (i_r == LAST_IDX) begin
            i_nxt     = '0;
            bank_nxt  = zflag_r ? bank_r : ~bank_r;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt = i_r + 1'b1;
            if (op_r == OP_MOVE) begin
              state_nxt = ST_M_RD;
            end else if (zflag_r) begin
              state_nxt = ST_Z_RD;
            end else begin
              state_nxt = ST_D_RD;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      i_r         <= '0;
      bank_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wmap_r      <= WORLD_MAP_RST;
      hit_r       <= HIT_RST;
      miss_r      <= MISS_RST;
      exact_r     <= EXACT_RST;
      over_r      <= OVER_RST;
      under_r     <= UNDER_RST;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      bank_r      <= bank_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WORLD_MAP: wmap_r  <= cfg_data;
          CFG_HIT:       hit_r   <= cfg_data;
          CFG_MISS:      miss_r  <= cfg_data;
          CFG_EXACT:     exact_r <= cfg_data;
          CFG_OVER:      over_r  <= cfg_data;
          CFG_UNDER:     under_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    meas_r     <= meas_nxt;
    zflag_r    <= zflag_nxt;
    moff_r     <= moff_nxt;
    term_r     <= term_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dcnt_r     <= dcnt_nxt;
    sat_r      <= sat_nxt;
    res_r      <= res_nxt;
    out_idx_r  <= out_idx_nxt;
    out_prob_r <= out_prob_nxt;
    out_last_r <= out_last_nxt;
    out_zero_r <= out_zero_nxt;
  end

  // Belief store holds two banks: the current vector is read from one while
  // the new vector is written into the other.
  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[bwaddr] <= bwdata;
    end
    brdata_r <= bmem[braddr];
  end

  always_ff @(posedge clk) begin
    if (wwe) begin
      wmem[i_r] <= prod_r;
    end
    wrdata_r <= wmem[i_r];
  end

endmodule

### rtl/hf1d_checker.sv
// Port-level checks for the histogram filter top level, and the bind that
// attaches them. Depends on histogram_filter_1d_unit and its channel interfaces.
module hf1d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [3:0]  out_cell_index,
  input logic [15:0] out_probability
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready right after an item was accepted");

  a_no_accept_mid_vector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while a vector is still being delivered");

  a_not_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready during the belief load after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probability)
      && $stable(out_cell_index))
    else $error("stalled result changed");

endmodule

bind histogram_filter_1d_unit hf1d_checker u_hf1d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_last        (out_ch.last),
  .out_cell_index  (out_ch.cell_index),
  .out_probability (out_ch.probability)
);
